// File: src/assert_macros.svh
// Assertion helpers shared by the deframer RTL.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Plain invariant outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// File: src/gbfp_pkg.sv
// Shared types, constants and the CRC-32 byte step for the frame deframer.
// No dependencies.
package gbfp_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h44;
    localparam logic [7:0] SYNC_THIRD_RESET  = 8'h12;

    // Register indexes on the APB port (byte address / 4)
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_SYNC_THIRD  = 2'd2;

    localparam int HDR_CNT_W = 5;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_SYNC3  = 4'd2,
        PH_HEADER = 4'd3,
        PH_DATA   = 4'd4,
        PH_CHECK1 = 4'd5,
        PH_CHECK2 = 4'd6,
        PH_CHECK3 = 4'd7,
        PH_CHECK4 = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } sync_cfg_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [15:0] msg_id;
        logic [15:0] byte_index;
        logic [7:0]  payload_byte;
        logic        checksum_good;
        logic [15:0] payload_length;
    } result_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: src/gnss_binary_frame_parser_crc32_top.sv
// Top level of the binary frame deframer: APB sync registers, input handshake,
// output register. Depends on gbfp_pkg, gbfp_deframer and assert_macros.svh.
//
// Usage:
//   Input channel: one received byte (rx_byte) per word, in_valid / in_stall.
//   Output channel: out_valid / out_stall with result_kind, msg_id,
//   byte_index, payload_byte, checksum_good and payload_length as one word.
//   Payload bytes come out with their index; after the four check bytes a
//   frame-end word reports id, length and checksum_good.
//   A result appears on the outputs in the cycle after the byte that causes it
//   is accepted. Throughput: one byte per cycle while in_stall is low; framing,
//   header capture and the byte-wide CRC step all complete in the accept cycle.
//   Stall: while the output register holds a word and out_stall is high,
//   in_stall is high; no word is dropped and the held word does not change.
//   Reset: sync bytes return to AA 44 12, the parser hunts for the first sync
//   byte and the output register is empty. Sync registers sit at byte addresses
//   0, 4 and 8; the user must write them only while idle, the block does not check.
`include "assert_macros.svh"

module gnss_binary_frame_parser_crc32_top
    import gbfp_pkg::*;
#(
    parameter int HEADER_BYTES  = 28,
    parameter int ID_OFFSET     = 4,
    parameter int LENGTH_OFFSET = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] msg_id,
    output logic [15:0] byte_index,
    output logic [7:0]  payload_byte,
    output logic        checksum_good,
    output logic [15:0] payload_length
);

    sync_cfg_t   sync_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;
    logic        in_take;
    result_t     res;
    logic        out_valid_reg;
    result_t     out_reg;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sync_reg.first  <= SYNC_FIRST_RESET;
            sync_reg.second <= SYNC_SECOND_RESET;
            sync_reg.third  <= SYNC_THIRD_RESET;
        end
        else if (cfg_write) begin
            case (reg_index)
                REG_SYNC_FIRST:  sync_reg.first  <= pwdata[7:0];
                REG_SYNC_SECOND: sync_reg.second <= pwdata[7:0];
                REG_SYNC_THIRD:  sync_reg.third  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_SYNC_FIRST:  prdata = {24'h0, sync_reg.first};
            REG_SYNC_SECOND: prdata = {24'h0, sync_reg.second};
            REG_SYNC_THIRD:  prdata = {24'h0, sync_reg.third};
            default:         prdata = 32'h0;
        endcase
    end

    // Hold off input only when a finished word is stuck in the output register
    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    gbfp_deframer #(
        .HEADER_BYTES  (HEADER_BYTES),
        .ID_OFFSET     (ID_OFFSET),
        .LENGTH_OFFSET (LENGTH_OFFSET)
    ) u_deframer (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (in_take),
        .rx_byte  (rx_byte),
        .sync_cfg (sync_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_take)
            out_valid_reg <= res.valid;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (in_take && res.valid)
            out_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_reg.kind;
    assign msg_id         = out_reg.msg_id;
    assign byte_index     = out_reg.byte_index;
    assign payload_byte   = out_reg.payload_byte;
    assign checksum_good  = out_reg.checksum_good;
    assign payload_length = out_reg.payload_length;

    `ASSERT_NEXT(a_result_shown, clk, rst_n, in_take && res.valid,
        out_valid, "accepted result not presented")
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, !in_take && !out_valid_reg,
        !out_valid, "output word appeared without an accepted byte")
    `ASSERT_IMPL(a_frame_end_fields, clk, rst_n, out_valid && result_kind == KIND_FRAME_END,
        byte_index == 16'h0 && payload_byte == 8'h0, "frame-end word carries payload data")

endmodule

// File: src/gbfp_deframer.sv
// Framing state machine, header capture and running CRC for one byte per cycle while take is high.
// Depends on gbfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gbfp_deframer
    import gbfp_pkg::*;
#(
    parameter int HEADER_BYTES  = 28,
    parameter int ID_OFFSET     = 4,
    parameter int LENGTH_OFFSET = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic [7:0] rx_byte,
    input  sync_cfg_t sync_cfg,
    output result_t   res
);

    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES);
    localparam logic [HDR_CNT_W-1:0] ID_LO    = HDR_CNT_W'(ID_OFFSET);
    localparam logic [HDR_CNT_W-1:0] ID_HI    = HDR_CNT_W'(ID_OFFSET + 1);
    localparam logic [HDR_CNT_W-1:0] LEN_LO   = HDR_CNT_W'(LENGTH_OFFSET);
    localparam logic [HDR_CNT_W-1:0] LEN_HI   = HDR_CNT_W'(LENGTH_OFFSET + 1);
    localparam logic [HDR_CNT_W-1:0] CNT_ONE  = HDR_CNT_W'(1);

    phase_t                phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]  header_count_reg, header_count_next;
    logic [15:0]           frame_id_reg, frame_id_next;
    logic [15:0]           frame_length_reg, frame_length_next;
    logic [15:0]           payload_count_reg, payload_count_next;
    logic [31:0]           crc_reg, crc_next;
    logic [23:0]           check_reg, check_next;

    logic                  hunt_like;
    logic [HDR_CNT_W-1:0]  pos;
    logic [15:0]           id_take, len_take;
    logic [31:0]           crc_base, crc_take;
    logic [HDR_CNT_W-1:0]  count_take;
    logic [15:0]           payload_inc;
    logic [31:0]           check_word;

    // Header byte capture; a new frame starts from cleared fields
    always_comb begin
        hunt_like = !(phase_reg inside {PH_SYNC2, PH_SYNC3, PH_HEADER, PH_DATA,
                                        PH_CHECK1, PH_CHECK2, PH_CHECK3, PH_CHECK4});
        pos        = hunt_like ? '0 : header_count_reg;
        id_take    = hunt_like ? 16'h0 : frame_id_reg;
        len_take   = hunt_like ? 16'h0 : frame_length_reg;
        crc_base   = hunt_like ? 32'h0 : crc_reg;
        if (pos == ID_LO)  id_take[7:0]   = rx_byte;
        if (pos == ID_HI)  id_take[15:8]  = rx_byte;
        if (pos == LEN_LO) len_take[7:0]  = rx_byte;
        if (pos == LEN_HI) len_take[15:8] = rx_byte;
        crc_take    = crc_byte(crc_base, rx_byte);
        count_take  = pos + CNT_ONE;
        payload_inc = payload_count_reg + 16'd1;
        check_word  = {rx_byte, check_reg};
    end

    // Next phase
    always_comb begin
        case (phase_reg)
            PH_SYNC2:  phase_next = (rx_byte == sync_cfg.second) ? PH_SYNC3 : PH_HUNT;
            PH_SYNC3:  phase_next = (rx_byte == sync_cfg.third) ? PH_HEADER : PH_HUNT;
            PH_HEADER: begin
                if (count_take >= HDR_LAST)
                    phase_next = (len_take == 16'h0) ? PH_CHECK1 : PH_DATA;
                else
                    phase_next = PH_HEADER;
            end
            PH_DATA:   phase_next = (payload_inc == frame_length_reg) ? PH_CHECK1 : PH_DATA;
            PH_CHECK1: phase_next = PH_CHECK2;
            PH_CHECK2: phase_next = PH_CHECK3;
            PH_CHECK3: phase_next = PH_CHECK4;
            PH_CHECK4: phase_next = PH_HUNT;
            default:   phase_next = (rx_byte == sync_cfg.first) ? PH_SYNC2 : PH_HUNT;
        endcase
    end

    // Datapath updates and result
    always_comb begin
        header_count_next  = header_count_reg;
        frame_id_next      = frame_id_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        crc_next           = crc_reg;
        check_next         = check_reg;
        res                = '0;
        res.msg_id         = frame_id_reg;
        res.payload_length = frame_length_reg;
        case (phase_reg)
            PH_SYNC2, PH_SYNC3: begin
                if ((phase_reg == PH_SYNC2 && rx_byte == sync_cfg.second) ||
                    (phase_reg == PH_SYNC3 && rx_byte == sync_cfg.third)) begin
                    header_count_next = count_take;
                    frame_id_next     = id_take;
                    frame_length_next = len_take;
                    crc_next          = crc_take;
                end
            end
            PH_HEADER: begin
                header_count_next = count_take;
                frame_id_next     = id_take;
                frame_length_next = len_take;
                crc_next          = crc_take;
                if (count_take >= HDR_LAST)
                    payload_count_next = 16'h0;
            end
            PH_DATA: begin
                res.valid          = 1'b1;
                res.kind           = KIND_PAYLOAD;
                res.byte_index     = payload_count_reg;
                res.payload_byte   = rx_byte;
                crc_next           = crc_take;
                payload_count_next = payload_inc;
            end
            PH_CHECK1: check_next = {16'h0, rx_byte};
            PH_CHECK2: check_next = {8'h0, rx_byte, check_reg[7:0]};
            PH_CHECK3: check_next = {rx_byte, check_reg[15:0]};
            PH_CHECK4: begin
                res.valid         = 1'b1;
                res.kind          = KIND_FRAME_END;
                res.checksum_good = (check_word == crc_reg);
            end
            default: begin
                header_count_next = '0;
                if (rx_byte == sync_cfg.first) begin
                    header_count_next = count_take;
                    frame_id_next     = id_take;
                    frame_length_next = len_take;
                    crc_next          = crc_take;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg         <= PH_HUNT;
            header_count_reg  <= '0;
            frame_id_reg      <= 16'h0;
            frame_length_reg  <= 16'h0;
            payload_count_reg <= 16'h0;
            crc_reg           <= 32'h0;
            check_reg         <= 24'h0;
        end
        else if (take) begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_id_reg      <= frame_id_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            crc_reg           <= crc_next;
            check_reg         <= check_next;
        end
    end

    `ASSERT_IMPL(a_result_phase, clk, rst_n, res.valid,
        (phase_reg == PH_DATA || phase_reg == PH_CHECK4), "result outside payload/check phase")
    `ASSERT_NEXT(a_end_to_hunt, clk, rst_n, take && phase_reg == PH_CHECK4,
        phase_reg == PH_HUNT, "frame end did not return to hunt")
    `ASSERT_ALWAYS(a_hdr_count, clk, rst_n, header_count_reg <= HDR_LAST,
        "header count ran past header length")

endmodule

// File: dv/tb_gnss_binary_frame_parser_crc32_top.sv
// Testbench for gnss_binary_frame_parser_crc32_top: drives framed byte streams, noise and
// broken sync runs, checks every result word against a behavioral deframer with its own CRC.
// Depends on gbfp_pkg and the RTL of the top level.
module tb_gnss_binary_frame_parser_crc32_top;
    import gbfp_pkg::*;

    localparam int HEADER_BYTES   = 28;
    localparam int ID_OFFSET      = 4;
    localparam int LENGTH_OFFSET  = 8;
    localparam logic [31:0] CRC32_REFL_POLY = 32'hEDB88320;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int RANDOM_BYTES   = 750;
    localparam int CONFIG_PHASES  = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [15:0] msg_id;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
    logic        checksum_good;
    logic [15:0] payload_length;

    gnss_binary_frame_parser_crc32_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .msg_id         (msg_id),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .checksum_good  (checksum_good),
        .payload_length (payload_length)
    );

    typedef struct {
        logic        kind;
        logic [15:0] id;
        logic [15:0] index;
        logic [7:0]  data;
        logic        good;
        logic [15:0] length;
    } deframed_t;

    deframed_t deframed_q[$];

    // deframer state mirror
    sync_cfg_t   sync_cfg;
    phase_t      phase;
    logic [4:0]  hdr_count;
    logic [15:0] frame_id;
    logic [15:0] frame_len;
    logic [15:0] pay_count;
    logic [31:0] frame_crc;
    logic [23:0] check_low;

    int mismatch_count;
    int idle_cycles;
    int frame_bytes;
    int in_busy_pct;
    int out_busy_pct;
    int stall_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic [31:0] crc32_refl_update(input logic [31:0] crc,
                                                      input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC32_REFL_POLY;
        end
        return c;
    endfunction

    // no gap unless the busy percentage hits, then short ones, rarely a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 6);
        return $urandom_range(3, 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic take_header_byte(input logic [7:0] b);
        if (hdr_count == ID_OFFSET)
            frame_id[7:0] = b;
        if (hdr_count == ID_OFFSET + 1)
            frame_id[15:8] = b;
        if (hdr_count == LENGTH_OFFSET)
            frame_len[7:0] = b;
        if (hdr_count == LENGTH_OFFSET + 1)
            frame_len[15:8] = b;
        frame_crc = crc32_refl_update(frame_crc, b);
        hdr_count = hdr_count + 5'd1;
    endtask

    task automatic deframe_step(input logic [7:0] b);
        deframed_t r;
        r.kind   = KIND_PAYLOAD;
        r.id     = frame_id;
        r.index  = 16'h0;
        r.data   = 8'h0;
        r.good   = 1'b0;
        r.length = frame_len;
        case (phase)
            PH_SYNC2:
            begin
                if (b == sync_cfg.second)
                begin
                    take_header_byte(b);
                    phase = PH_SYNC3;
                end
                else
                    phase = PH_HUNT;
            end
            PH_SYNC3:
            begin
                if (b == sync_cfg.third)
                begin
                    take_header_byte(b);
                    phase = PH_HEADER;
                end
                else
                    phase = PH_HUNT;
            end
            PH_HEADER:
            begin
                take_header_byte(b);
                if (hdr_count >= HEADER_BYTES)
                begin
                    pay_count = 16'h0;
                    phase = (frame_len == 16'h0) ? PH_CHECK1 : PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.index = pay_count;
                r.data  = b;
                deframed_q.push_back(r);
                frame_crc = crc32_refl_update(frame_crc, b);
                pay_count = pay_count + 16'd1;
                if (pay_count == frame_len)
                    phase = PH_CHECK1;
            end
            PH_CHECK1:
            begin
                check_low[7:0] = b;
                phase = PH_CHECK2;
            end
            PH_CHECK2:
            begin
                check_low[15:8] = b;
                phase = PH_CHECK3;
            end
            PH_CHECK3:
            begin
                check_low[23:16] = b;
                phase = PH_CHECK4;
            end
            PH_CHECK4:
            begin
                r.kind = KIND_FRAME_END;
                r.good = ({b, check_low} == frame_crc);
                deframed_q.push_back(r);
                phase = PH_HUNT;
            end
            default:
            begin
                hdr_count = 5'd0;
                if (b == sync_cfg.first)
                begin
                    frame_id  = 16'h0;
                    frame_len = 16'h0;
                    frame_crc = 32'h0;
                    take_header_byte(b);
                    phase = PH_SYNC2;
                end
                else
                    phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(in_busy_pct);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do
            @(posedge clk);
        while (in_stall);
        deframe_step(b);
    endtask

    task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                              input bit bad_fcs, input int fill);
        logic [31:0] fcs;
        logic [7:0]  b;
        fcs = 32'h0;
        for (int pos = 0; pos < HEADER_BYTES; pos++)
        begin
            if (pos == 0)
                b = sync_cfg.first;
            else if (pos == 1)
                b = sync_cfg.second;
            else if (pos == 2)
                b = sync_cfg.third;
            else if (pos == ID_OFFSET)
                b = id[7:0];
            else if (pos == ID_OFFSET + 1)
                b = id[15:8];
            else if (pos == LENGTH_OFFSET)
                b = len[7:0];
            else if (pos == LENGTH_OFFSET + 1)
                b = len[15:8];
            else
                b = 8'($urandom);
            fcs = crc32_refl_update(fcs, b);
            send_byte(b);
        end
        for (int i = 0; i < len; i++)
        begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            fcs = crc32_refl_update(fcs, b);
            send_byte(b);
        end
        if (bad_fcs)
            fcs = fcs ^ (32'h1 << $urandom_range(31));
        send_byte(fcs[7:0]);
        send_byte(fcs[15:8]);
        send_byte(fcs[23:16]);
        send_byte(fcs[31:24]);
        frame_bytes += HEADER_BYTES + len + 4;
    endtask

    task automatic send_noise(input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            do
                b = 8'($urandom);
            while (b == sync_cfg.first);
            send_byte(b);
        end
    endtask

    // sync run that breaks at the second or third byte
    task automatic send_broken_sync();
        logic [7:0] b;
        send_byte(sync_cfg.first);
        if ($urandom_range(1))
        begin
            do
                b = 8'($urandom);
            while (b == sync_cfg.second);
        end
        else
        begin
            send_byte(sync_cfg.second);
            do
                b = 8'($urandom);
            while (b == sync_cfg.third);
        end
        send_byte(b);
    endtask

    // no byte may still be in flight when a register changes
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = ($urandom() & 32'hFFFF_FF00) | {24'h0, val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_SYNC_FIRST:  sync_cfg.first  = val;
            REG_SYNC_SECOND: sync_cfg.second = val;
            REG_SYNC_THIRD:  sync_cfg.third  = val;
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_sync_regs();
        logic [31:0] d;
        apb_read(REG_SYNC_FIRST, d);
        if (d !== {24'h0, sync_cfg.first})
            report_mismatch("sync_first readback", d, {24'h0, sync_cfg.first});
        apb_read(REG_SYNC_SECOND, d);
        if (d !== {24'h0, sync_cfg.second})
            report_mismatch("sync_second readback", d, {24'h0, sync_cfg.second});
        apb_read(REG_SYNC_THIRD, d);
        if (d !== {24'h0, sync_cfg.third})
            report_mismatch("sync_third readback", d, {24'h0, sync_cfg.third});
    endtask

    task automatic write_sync_regs(input logic [7:0] s1, input logic [7:0] s2,
                                   input logic [7:0] s3);
        wait_idle();
        apb_write(REG_SYNC_FIRST, s1);
        apb_write(REG_SYNC_SECOND, s2);
        apb_write(REG_SYNC_THIRD, s3);
        check_sync_regs();
    endtask

    task automatic test_reset_defaults();
        in_busy_pct  = 0;
        out_busy_pct = 0;
        check_sync_regs();
        send_frame(16'h0000, 16'd0, 1'b0, -1);
        send_frame(16'hFFFF, 16'd1, 1'b0, 8'hFF);
        send_frame(16'h8001, 16'd2, 1'b1, 8'h00);
        send_frame(16'h1234, 16'd0, 1'b1, -1);
    endtask

    task automatic test_sync_mismatch();
        in_busy_pct  = 30;
        out_busy_pct = 30;
        // a byte that breaks the sync run is not taken as a new first sync byte
        send_byte(sync_cfg.first);
        send_byte(sync_cfg.first);
        send_byte(sync_cfg.second);
        send_byte(sync_cfg.third);
        send_noise(3);
        send_byte(sync_cfg.first);
        send_byte(sync_cfg.second);
        send_byte(sync_cfg.first);
        send_byte(sync_cfg.second);
        send_byte(sync_cfg.third);
        send_noise(2);
        send_frame(16'h00A5, 16'd3, 1'b0, -1);
    endtask

    task automatic test_register_map();
        wait_idle();
        apb_write(REG_UNMAPPED, 8'h5A);
        check_sync_regs();
        write_sync_regs(8'h00, 8'hFF, 8'h00);
        send_frame(16'h7FFF, 16'd4, 1'b0, -1);
        write_sync_regs(8'hFF, 8'h00, 8'hFF);
        send_frame(16'h0100, 16'd1, 1'b0, -1);
        send_broken_sync();
        write_sync_regs(8'h00, 8'h00, 8'h00);
        send_frame(16'h00FF, 16'd2, 1'b1, -1);
    endtask

    task automatic test_random_frames();
        int sel;
        int big_frames;
        int target;
        logic [7:0]  s;
        logic [15:0] len;
        big_frames = 0;
        frame_bytes = 0;
        for (int ph = 0; ph < CONFIG_PHASES; ph++)
        begin
            s = 8'($urandom);
            case (ph)
                1:       write_sync_regs(8'h00, 8'h00, 8'h00);
                2:       write_sync_regs(8'hFF, 8'hFF, 8'hFF);
                3:       write_sync_regs(8'h00, 8'hFF, 8'h00);
                4:       write_sync_regs(8'hFF, 8'h00, 8'hFF);
                6:       write_sync_regs(s, s, 8'($urandom));
                7:       write_sync_regs(SYNC_FIRST_RESET, SYNC_SECOND_RESET,
                                         SYNC_THIRD_RESET);
                default: write_sync_regs(s, 8'($urandom), 8'($urandom));
            endcase
            target = (ph + 1) * RANDOM_BYTES / CONFIG_PHASES;
            while (frame_bytes < target)
            begin
                case ($urandom_range(2))
                    0:       in_busy_pct = 0;
                    1:       in_busy_pct = 25;
                    default: in_busy_pct = 70;
                endcase
                case ($urandom_range(2))
                    0:       out_busy_pct = 0;
                    1:       out_busy_pct = 25;
                    default: out_busy_pct = 70;
                endcase
                sel = $urandom_range(99);
                if (sel < 8)
                    send_noise($urandom_range(6, 1));
                else if (sel < 15)
                    send_broken_sync();
                else
                begin
                    sel = $urandom_range(99);
                    if (sel < 4 && big_frames < 3)
                    begin
                        len = 16'($urandom_range(300, 200));
                        big_frames++;
                    end
                    else if (sel < 30)
                        len = 16'($urandom_range(48, 13));
                    else
                        len = 16'($urandom_range(12, 0));
                    send_frame(16'($urandom), len, $urandom_range(4) == 0, -1);
                end
            end
        end
    endtask

    // receiver back-pressure
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap(out_busy_pct);
            out_stall = (stall_left > 0);
        end
    end

    always @(posedge clk)
    begin
        deframed_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (deframed_q.size() == 0)
                report_mismatch("unexpected word, kind", 32'(result_kind), 32'h0);
            else
            begin
                want = deframed_q.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
                if (msg_id !== want.id)
                    report_mismatch("msg_id", 32'(msg_id), 32'(want.id));
                if (byte_index !== want.index)
                    report_mismatch("byte_index", 32'(byte_index), 32'(want.index));
                if (payload_byte !== want.data)
                    report_mismatch("payload_byte", 32'(payload_byte), 32'(want.data));
                if (checksum_good !== want.good)
                    report_mismatch("checksum_good", 32'(checksum_good), 32'(want.good));
                if (payload_length !== want.length)
                    report_mismatch("payload_length", 32'(payload_length),
                                    32'(want.length));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("gnss_binary_frame_parser_crc32_top verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 4'h0;
        pwdata   = 32'h0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        in_busy_pct    = 0;
        out_busy_pct   = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        frame_bytes    = 0;
        sync_cfg.first  = SYNC_FIRST_RESET;
        sync_cfg.second = SYNC_SECOND_RESET;
        sync_cfg.third  = SYNC_THIRD_RESET;
        phase     = PH_HUNT;
        hdr_count = 5'd0;
        frame_id  = 16'h0;
        frame_len = 16'h0;
        pay_count = 16'h0;
        frame_crc = 32'h0;
        check_low = 24'h0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_sync_mismatch();
        test_register_map();
        test_random_frames();

        wait_idle();
        if (mismatch_count == 0)
            $display("gnss_binary_frame_parser_crc32_top verification clean");
        else
            $display("gnss_binary_frame_parser_crc32_top verification failed");
        $finish;
    end

endmodule
